@@ hdl/ecge_pkg.sv @@
// Shared types and constants for the excitable cell grid engine.
`default_nettype none

package ecge_pkg;

  // One grid cell holds one of six states.
  typedef logic [2:0] cell_t;

  localparam cell_t CELL_VACUUM  = 3'd0;
  localparam cell_t CELL_WAIT    = 3'd1;
  localparam cell_t CELL_INFO    = 3'd2;
  localparam cell_t CELL_CONTROL = 3'd3;
  localparam cell_t CELL_GOAL    = 3'd4;
  localparam cell_t CELL_BROKEN  = 3'd5;

  // Command codes.
  localparam logic [2:0] KIND_WRITE = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_CYCLE = 3'd2;
  localparam logic [2:0] KIND_STEP  = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  // Configuration register indexes.
  localparam int CFG_W = 7;
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd64;

  // Change counter saturates at its top value.
  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

  // Moore neighbourhood size.
  localparam int NBR_COUNT = 8;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] col;
    logic [5:0] row;
    logic [2:0] new_state;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         cell_state;
    logic [COUNT_W-1:0] changed_cells;
  } result_t;

  // Outcome of updating one cell over one generation.
  typedef struct packed {
    cell_t next_cell;
    logic  changed;
  } cell_update_t;

endpackage

`default_nettype wire

@@ hdl/excitable_cell_grid_engine_top.sv @@
// Top level of the excitable cell grid engine: row store, sequencer and scan datapath.
//
// Commands enter on cmd and are transferred at a rising edge with start high and busy low.
// Each command gives one result on result, marked by done for exactly one cycle; the
// receiver must take it then. A new command can be transferred in the cycle done is high.
// The grid lives in a row-wide synchronous memory holding two generations; a single-cell
// write, read or cycle fetches its row into the read register, then writes the row back
// (write and cycle only, in bounds) and registers the result. A step sweeps every row of
// the current generation: each row is loaded, rotated through a three-row window one
// column per cycle and written to the other generation.
// Clear all writes vacuum to every row of the current generation, one row per cycle.
// Unused command codes answer with an all-zero result the cycle after the transfer.
// After reset the block runs a clearing pass with busy high; grid width and height
// return to 64. Configuration writes are taken at any time, but only while no command
// is in progress do they have a defined effect.
`default_nettype none

module excitable_cell_grid_engine_top #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  ecge_pkg::cmd_t                  cmd,
  output logic                            done,
  output ecge_pkg::result_t               result,
  input  logic                            cfg_we,
  input  logic                            cfg_idx,
  input  logic [ecge_pkg::CFG_W-1:0]      cfg_wdata
);
  import ecge_pkg::*;

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int UCW   = $clog2(MAX_COLS + 1);
  localparam int URW   = $clog2(MAX_ROWS + 1);
  localparam int AW    = RW + 1;
  localparam int DEPTH = 2 ** AW;

  typedef logic [MAX_COLS-1:0][2:0] row_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL,
    S_PRIME,
    S_LOAD,
    S_SCAN,
    S_WRITE,
    S_CLEAR
  } state_t;

  state_t             state;
  logic               bank;
  logic               clr_report;
  cmd_t               req;
  logic [CW-1:0]      scan_col;
  logic [RW-1:0]      scan_row;
  logic [COUNT_W-1:0] count;
  row_t               top;
  row_t               mid;
  row_t               bot;
  row_t               out_row;

  logic [CFG_W-1:0]   grid_width;
  logic [CFG_W-1:0]   grid_height;
  logic [UCW-1:0]     used_cols;
  logic [URW-1:0]     used_rows;

  // Row memory: two generations, one write and one read port.
  row_t               mem [DEPTH];
  row_t               q;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  row_t               wr_data;

  // Single-cell datapath.
  logic [CW-1:0]      col_idx;
  cell_t              old_cell;
  cell_t              new_cell;
  row_t               cell_row;
  logic               in_bounds;

  // Scan datapath.
  logic                          has_left;
  logic                          has_right;
  logic                          has_up;
  logic                          has_down;
  logic                          scan_in_use;
  logic [NBR_COUNT-1:0][2:0]     nbrs;
  logic [NBR_COUNT-1:0]          nbr_valid;
  cell_update_t                  upd;
  logic                          last_col;
  logic                          last_row;

  function automatic cell_t click_next(input cell_t s);
    case (s)
      CELL_VACUUM:  return CELL_WAIT;
      CELL_WAIT:    return CELL_INFO;
      CELL_INFO:    return CELL_CONTROL;
      CELL_CONTROL: return CELL_BROKEN;
      CELL_BROKEN:  return CELL_VACUUM;
      default:      return s;
    endcase
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_SIZE_RESET;
      grid_height <= GRID_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GRID_WIDTH:  grid_width  <= cfg_wdata;
        REG_GRID_HEIGHT: grid_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Grid size in use: zero acts as one, oversize values clamp to the array size.
  always_comb begin
    if (grid_width == '0) begin
      used_cols = UCW'(1);
    end else if (grid_width > MAX_COLS) begin
      used_cols = UCW'(MAX_COLS);
    end else begin
      used_cols = UCW'(grid_width);
    end
    if (grid_height == '0) begin
      used_rows = URW'(1);
    end else if (grid_height > MAX_ROWS) begin
      used_rows = URW'(MAX_ROWS);
    end else begin
      used_rows = URW'(grid_height);
    end
  end

  // Row memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  // Read-modify-write of the addressed cell within the fetched row.
  assign col_idx   = CW'(req.col);
  assign old_cell  = q[col_idx];
  assign in_bounds = (req.col < used_cols) && (req.row < used_rows);

  always_comb begin
    case (req.kind)
      KIND_WRITE: new_cell = (req.new_state <= CELL_BROKEN) ? req.new_state : old_cell;
      KIND_CYCLE: new_cell = click_next(old_cell);
      default:    new_cell = old_cell;
    endcase
    cell_row          = q;
    cell_row[col_idx] = new_cell;
  end

  // Window position flags. Column c sits at tap 0, c+1 at tap 1 and c-1 at the last tap.
  assign has_left    = scan_col != '0;
  assign has_right   = (UCW'(scan_col) + UCW'(1)) < used_cols;
  assign has_up      = scan_row != '0;
  assign has_down    = (URW'(scan_row) + URW'(1)) < used_rows;
  assign scan_in_use = (UCW'(scan_col) < used_cols) && (URW'(scan_row) < used_rows);
  assign last_col    = scan_col == CW'(MAX_COLS - 1);
  assign last_row    = scan_row == RW'(MAX_ROWS - 1);

  always_comb begin
    nbrs[0] = top[MAX_COLS-1];
    nbrs[1] = top[0];
    nbrs[2] = top[1];
    nbrs[3] = mid[MAX_COLS-1];
    nbrs[4] = mid[1];
    nbrs[5] = bot[MAX_COLS-1];
    nbrs[6] = bot[0];
    nbrs[7] = bot[1];
    nbr_valid[0] = has_up && has_left;
    nbr_valid[1] = has_up;
    nbr_valid[2] = has_up && has_right;
    nbr_valid[3] = has_left;
    nbr_valid[4] = has_right;
    nbr_valid[5] = has_down && has_left;
    nbr_valid[6] = has_down;
    nbr_valid[7] = has_down && has_right;
  end

  ecge_cell_rule u_rule (
    .centre    (mid[0]),
    .nbrs      (nbrs),
    .nbr_valid (nbr_valid),
    .in_use    (scan_in_use),
    .update    (upd)
  );

  // Memory port control for each sequencer state.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {bank, RW'(cmd.row)};
    wr_en   = 1'b0;
    wr_addr = {bank, scan_row};
    wr_data = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          rd_en = 1'b1;
          if (cmd.kind == KIND_STEP) begin
            rd_addr = {bank, {RW{1'b0}}};
          end
        end
      end
      S_PRIME: begin
        rd_en   = 1'b1;
        rd_addr = {bank, scan_row + RW'(1)};
      end
      S_CELL: begin
        wr_en   = in_bounds && (req.kind == KIND_WRITE || req.kind == KIND_CYCLE);
        wr_addr = {bank, RW'(req.row)};
        wr_data = cell_row;
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = {~bank, scan_row};
        wr_data = out_row;
        rd_en   = 1'b1;
        rd_addr = {bank, scan_row + RW'(2)};
      end
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = {bank, scan_row};
      end
      default: ;
    endcase
  end

  assign busy = state != S_IDLE;

  // Sequencer, scan registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      bank       <= 1'b0;
      clr_report <= 1'b0;
      scan_row   <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req <= cmd;
            case (cmd.kind)
              KIND_WRITE, KIND_READ, KIND_CYCLE: begin
                state <= S_CELL;
              end
              KIND_STEP: begin
                scan_row <= '0;
                count    <= '0;
                state    <= S_PRIME;
              end
              KIND_CLEAR: begin
                scan_row   <= '0;
                clr_report <= 1'b1;
                state      <= S_CLEAR;
              end
              default: begin
                done   <= 1'b1;
                result <= '0;
              end
            endcase
          end
        end
        S_CELL: begin
          done                 <= 1'b1;
          result.cell_state    <= in_bounds ? new_cell : CELL_VACUUM;
          result.changed_cells <= '0;
          state                <= S_IDLE;
        end
        S_PRIME: begin
          mid   <= q;
          state <= S_LOAD;
        end
        S_LOAD: begin
          bot      <= q;
          scan_col <= '0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          // Rotate the window one column; a full row of rotations restores each row.
          top     <= {top[0], top[MAX_COLS-1:1]};
          mid     <= {mid[0], mid[MAX_COLS-1:1]};
          bot     <= {bot[0], bot[MAX_COLS-1:1]};
          out_row <= {upd.next_cell, out_row[MAX_COLS-1:1]};
          if (upd.changed && count != COUNT_MAX) begin
            count <= count + COUNT_W'(1);
          end
          if (last_col) begin
            state <= S_WRITE;
          end else begin
            scan_col <= scan_col + CW'(1);
          end
        end
        S_WRITE: begin
          top <= mid;
          mid <= bot;
          if (last_row) begin
            bank                 <= ~bank;
            done                 <= 1'b1;
            result.cell_state    <= CELL_VACUUM;
            result.changed_cells <= count;
            state                <= S_IDLE;
          end else begin
            scan_row <= scan_row + RW'(1);
            state    <= S_LOAD;
          end
        end
        S_CLEAR: begin
          if (last_row) begin
            if (clr_report) begin
              done   <= 1'b1;
              result <= '0;
            end
            clr_report <= 1'b0;
            state      <= S_IDLE;
          end else begin
            scan_row <= scan_row + RW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/ecge_cell_rule.sv @@
// Generation rule for one cell from its Moore neighbourhood.
`default_nettype none

module ecge_cell_rule (
  input  ecge_pkg::cell_t                               centre,
  input  logic [ecge_pkg::NBR_COUNT-1:0][2:0]           nbrs,
  input  logic [ecge_pkg::NBR_COUNT-1:0]                nbr_valid,
  input  logic                                          in_use,
  output ecge_pkg::cell_update_t                        update
);
  import ecge_pkg::*;

  logic [NBR_COUNT-1:0] nbr_hot;
  logic                 excited;
  cell_t                evolved;

  // A neighbour excites only if it lies inside the grid and carries a signal.
  always_comb begin
    for (int i = 0; i < NBR_COUNT; i++) begin
      nbr_hot[i] = nbr_valid[i] && (nbrs[i] == CELL_INFO || nbrs[i] == CELL_CONTROL);
    end
  end

  assign excited = |nbr_hot;

  // Vacuum fires, info decays to wait, wait recovers; the rest hold.
  always_comb begin
    case (centre)
      CELL_VACUUM: evolved = excited ? CELL_INFO : CELL_VACUUM;
      CELL_INFO:   evolved = CELL_WAIT;
      CELL_WAIT:   evolved = CELL_VACUUM;
      default:     evolved = centre;
    endcase
  end

  // Cells beyond the grid in use keep their value and are not counted.
  assign update.next_cell = in_use ? evolved : centre;
  assign update.changed   = in_use && (evolved != centre);

endmodule

`default_nettype wire
